>>> rtl/drs_pkg.sv
// Shared constants, types and state encoding for the distinct random index sampler.
// No dependencies; every other file in the block refers to this package by scoped names.

package drs_pkg;

   // Field widths of the request and response items.
   localparam int CNT_W   = 11;
   localparam int INDEX_W = 10;
   localparam int MULT_W  = 32;
   localparam int STATE_W = 64;
   localparam int HALF_W  = 32;

   // Range limits and generator constants.
   localparam int MAX_POINTS       = 1024;
   localparam int SAMPLE_COUNT_DEF = 5;
   localparam int DRAW_LIMIT       = 4096;
   localparam int TRIES_W          = $clog2(DRAW_LIMIT + 1);
   localparam logic [MULT_W-1:0] MULT_RESET = 32'd4164903690;

   // Bit counter for the iterative remainder unit.
   localparam int STEP_W = $clog2(HALF_W);

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_EMIT,
      ST_FAIL
   } seq_state_type;

   // Controls from the sequencer to the generator.
   typedef struct packed {
      logic load_ones;
      logic mul_en;
      logic add_en;
   } mwc_ctrl_type;

   // Status from the remainder unit to the sequencer.
   typedef struct packed {
      logic               done;
      logic [CNT_W-1:0]   remainder;
   } urem_stat_type;

endpackage

>>> rtl/drs_ifs.sv
// Handshake channel interfaces: request, response and configuration write.
// Depends on drs_pkg for the payload widths.

interface drs_req_if;
   logic                         valid;
   logic                         ready;
   logic [drs_pkg::CNT_W-1:0]    point_count;
   logic                         restart;

   modport source (output valid, output point_count, output restart, input ready);
   modport sink   (input valid, input point_count, input restart, output ready);
endinterface

interface drs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [drs_pkg::INDEX_W-1:0]  index;
   logic                         last;
   logic                         error;

   modport source (output valid, output index, output last, output error, input ready);
   modport sink   (input valid, input index, input last, input error, output ready);
endinterface

interface drs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [drs_pkg::MULT_W-1:0]   multiplier;

   modport source (output valid, output multiplier, input ready);
   modport sink   (input valid, input multiplier, output ready);
endinterface

>>> rtl/drs_mwc.sv
// Multiply-with-carry generator: 64-bit state, one 32x32 multiply then one wide add.
// Depends on drs_pkg for widths and the control struct.

module drs_mwc (
   input  logic                          clock,
   input  logic                          reset,
   input  drs_pkg::mwc_ctrl_type         ctrl,
   input  logic [drs_pkg::MULT_W-1:0]    multiplier,
   output logic [drs_pkg::HALF_W-1:0]    low_word
);

   logic [drs_pkg::STATE_W-1:0] state_ff, state_in;
   logic [drs_pkg::STATE_W-1:0] product_ff, product_in;

   // The product of the low half is registered before the high half is added.
   always_comb begin
      product_in = product_ff;
      if (ctrl.mul_en) begin
         product_in = drs_pkg::STATE_W'(state_ff[drs_pkg::HALF_W-1:0]) *
                      drs_pkg::STATE_W'(multiplier);
      end
   end

   // State update: restart sets all ones, the add step completes a draw.
   always_comb begin
      state_in = state_ff;
      if (ctrl.load_ones) begin
         state_in = '1;
      end else if (ctrl.add_en) begin
         state_in = product_ff +
                    {{drs_pkg::HALF_W{1'b0}}, state_ff[drs_pkg::STATE_W-1:drs_pkg::HALF_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '1;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign low_word = state_ff[drs_pkg::HALF_W-1:0];

endmodule

>>> rtl/drs_urem.sv
// Iterative restoring remainder unit: 32-bit dividend by an 11-bit count, one bit a cycle.
// Depends on drs_pkg for widths and the status struct.

module drs_urem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drs_pkg::HALF_W-1:0]    dividend,
   input  logic [drs_pkg::CNT_W-1:0]     divisor,
   output drs_pkg::urem_stat_type        stat
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [drs_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [drs_pkg::HALF_W-1:0]    dvd_ff, dvd_in;
   logic [drs_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [drs_pkg::CNT_W-1:0]     trial;

   // The partial remainder stays below the divisor, so one shifted bit fits in CNT_W bits.
   assign trial = {rem_ff[drs_pkg::CNT_W-2:0], dvd_ff[drs_pkg::HALF_W-1]};

   // One restoring step per cycle while busy.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[drs_pkg::HALF_W-2:0], 1'b0};
         rem_in  = (trial >= divisor) ? (trial - divisor) : trial;
         step_in = step_ff + 1'b1;
         if (step_ff == drs_pkg::STEP_W'(drs_pkg::HALF_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;

endmodule

>>> rtl/distinct_random_index_sampler.sv
// Distinct random index sampler. One request at a time; not ready while a request is at work.
// Each draw runs multiply, add, divider load, 32 remainder steps, a wait for the remainder
// unit's registered done flag, then the duplicate check; the 32-step remainder unit sets the pace.
// A served request makes its draws, then gives one response item per cycle while the
// receiver is ready (SAMPLE_COUNT items); a short count answers with one error response in
// the cycle after the request is taken, and a pick that hits the draw limit ends in one too.
// Synchronous active-high reset: generator all ones, multiplier to its default, sequencer idle.

module distinct_random_index_sampler #(
   parameter int SAMPLE_COUNT = drs_pkg::SAMPLE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   drs_req_if.sink     req_chan,
   drs_rsp_if.source   rsp_chan,
   drs_csr_if.sink     csr_chan
);

   localparam int PICK_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam logic [PICK_W-1:0] LAST_PICK = PICK_W'(SAMPLE_COUNT - 1);

   drs_pkg::seq_state_type state_ff, state_in;

   logic [drs_pkg::MULT_W-1:0]    mult_ff, mult_in;
   logic [drs_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [drs_pkg::TRIES_W-1:0]   tries_ff, tries_in;
   logic [PICK_W-1:0]             pick_ff, pick_in;
   logic [drs_pkg::INDEX_W-1:0]   picks_ff [SAMPLE_COUNT];

   logic                          req_fire;
   logic                          rsp_fire;
   logic                          csr_fire;
   logic [drs_pkg::CNT_W-1:0]     sat_count;
   logic                          dup;
   logic                          store_pick;
   logic                          div_start;
   logic [drs_pkg::HALF_W-1:0]    low_word;
   drs_pkg::mwc_ctrl_type         mwc_ctrl;
   drs_pkg::urem_stat_type        div_stat;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;

   // Counts above the supported range are saturated.
   assign sat_count = (req_chan.point_count > drs_pkg::CNT_W'(drs_pkg::MAX_POINTS)) ?
                      drs_pkg::CNT_W'(drs_pkg::MAX_POINTS) : req_chan.point_count;

   // A draw is rejected if it matches any pick already made in this request.
   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
         if ((PICK_W'(j) < pick_ff) &&
             (picks_ff[j] == div_stat.remainder[drs_pkg::INDEX_W-1:0])) begin
            dup = 1'b1;
         end
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (sat_count < drs_pkg::CNT_W'(SAMPLE_COUNT)) begin
                  state_in = drs_pkg::ST_FAIL;
               end else begin
                  state_in = drs_pkg::ST_MUL;
               end
            end
         end
         drs_pkg::ST_MUL:  state_in = drs_pkg::ST_ADD;
         drs_pkg::ST_ADD:  state_in = drs_pkg::ST_LOAD;
         drs_pkg::ST_LOAD: state_in = drs_pkg::ST_DIV;
         drs_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = drs_pkg::ST_CHECK;
            end
         end
         drs_pkg::ST_CHECK: begin
            if (dup) begin
               if (tries_ff == drs_pkg::TRIES_W'(drs_pkg::DRAW_LIMIT)) begin
                  state_in = drs_pkg::ST_FAIL;
               end else begin
                  state_in = drs_pkg::ST_MUL;
               end
            end else if (pick_ff == LAST_PICK) begin
               state_in = drs_pkg::ST_EMIT;
            end else begin
               state_in = drs_pkg::ST_MUL;
            end
         end
         drs_pkg::ST_EMIT: begin
            if (rsp_fire && (pick_ff == LAST_PICK)) begin
               state_in = drs_pkg::ST_IDLE;
            end
         end
         drs_pkg::ST_FAIL: begin
            if (rsp_fire) begin
               state_in = drs_pkg::ST_IDLE;
            end
         end
         default: state_in = drs_pkg::ST_IDLE;
      endcase
   end

   // Output and control decode of the sequencer.
   always_comb begin
      req_chan.ready     = 1'b0;
      rsp_chan.valid     = 1'b0;
      rsp_chan.index     = '0;
      rsp_chan.last      = 1'b0;
      rsp_chan.error     = 1'b0;
      mwc_ctrl.load_ones = 1'b0;
      mwc_ctrl.mul_en    = 1'b0;
      mwc_ctrl.add_en    = 1'b0;
      div_start          = 1'b0;
      store_pick         = 1'b0;
      unique case (state_ff)
         drs_pkg::ST_IDLE: begin
            req_chan.ready     = 1'b1;
            mwc_ctrl.load_ones = req_chan.valid && req_chan.restart;
         end
         drs_pkg::ST_MUL:   mwc_ctrl.mul_en = 1'b1;
         drs_pkg::ST_ADD:   mwc_ctrl.add_en = 1'b1;
         drs_pkg::ST_LOAD:  div_start = 1'b1;
         drs_pkg::ST_DIV:   ;
         drs_pkg::ST_CHECK: store_pick = !dup;
         drs_pkg::ST_EMIT: begin
            rsp_chan.valid = 1'b1;
            rsp_chan.index = picks_ff[pick_ff];
            rsp_chan.last  = (pick_ff == LAST_PICK);
         end
         drs_pkg::ST_FAIL: begin
            rsp_chan.valid = 1'b1;
            rsp_chan.last  = 1'b1;
            rsp_chan.error = 1'b1;
         end
         default: ;
      endcase
   end

   // Request bookkeeping: count, draw attempts and pick position.
   always_comb begin
      count_in = count_ff;
      tries_in = tries_ff;
      pick_in  = pick_ff;
      if (req_fire) begin
         count_in = sat_count;
         tries_in = '0;
         pick_in  = '0;
      end
      if (mwc_ctrl.mul_en) begin
         tries_in = tries_ff + 1'b1;
      end
      if (store_pick) begin
         tries_in = '0;
         pick_in  = (pick_ff == LAST_PICK) ? '0 : (pick_ff + 1'b1);
      end
      if ((state_ff == drs_pkg::ST_EMIT) && rsp_fire) begin
         pick_in = (pick_ff == LAST_PICK) ? '0 : (pick_ff + 1'b1);
      end
   end

   // Configuration register; writes are taken at any time.
   assign csr_chan.ready = 1'b1;
   always_comb begin
      mult_in = csr_fire ? csr_chan.multiplier : mult_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drs_pkg::ST_IDLE;
         mult_ff  <= drs_pkg::MULT_RESET;
         tries_ff <= '0;
         pick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mult_ff  <= mult_in;
         tries_ff <= tries_in;
         pick_ff  <= pick_in;
      end
   end

   // Payload storage: the count and the picks of the request in progress.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      if (store_pick) begin
         picks_ff[pick_ff] <= div_stat.remainder[drs_pkg::INDEX_W-1:0];
      end
   end

   drs_mwc u_mwc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mwc_ctrl),
      .multiplier (mult_ff),
      .low_word   (low_word)
   );

   drs_urem u_urem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (low_word),
      .divisor  (count_ff),
      .stat     (div_stat)
   );

endmodule

>>> dv/index_sample_checker.sv
// Checker for the distinct random index sampler. It watches the request, response and
// configuration channels, predicts the indices of each request and compares the responses.
// Depends on drs_pkg and on the channel interfaces in drs_ifs.sv.

module index_sample_checker (
   input  logic clock,
   input  logic reset,
   drs_req_if   req_tap,
   drs_rsp_if   rsp_tap,
   drs_csr_if   csr_tap,
   output int   mismatch_count,
   output int   awaited_count
);

   localparam int PICKS        = drs_pkg::SAMPLE_COUNT_DEF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [drs_pkg::INDEX_W-1:0] index;
      logic                        last;
      logic                        error;
   } pick_result_type;

   // Own copy of the generator and of the multiplier register.
   logic [drs_pkg::STATE_W-1:0] mwc_state;
   logic [drs_pkg::MULT_W-1:0]  mwc_multiplier;
   pick_result_type             expected_picks[$];

   // One multiply-with-carry step; the draw is the new low half modulo the bound.
   function automatic logic [drs_pkg::HALF_W-1:0] mwc_draw(
      input logic [drs_pkg::HALF_W-1:0] bound);
      mwc_state = {{drs_pkg::HALF_W{1'b0}}, mwc_state[drs_pkg::HALF_W-1:0]} *
                  {{drs_pkg::HALF_W{1'b0}}, mwc_multiplier}
                  + {{drs_pkg::HALF_W{1'b0}},
                     mwc_state[drs_pkg::STATE_W-1:drs_pkg::HALF_W]};
      return mwc_state[drs_pkg::HALF_W-1:0] % bound;
   endfunction

   // Works out the responses of one request and queues them in order.
   task automatic predict_sample(input logic [drs_pkg::CNT_W-1:0] point_count,
                                 input logic restart);
      logic [drs_pkg::HALF_W-1:0]  bound;
      logic [drs_pkg::HALF_W-1:0]  cand;
      logic [drs_pkg::INDEX_W-1:0] picks [PICKS];
      pick_result_type             want;
      int                          tries;
      bit                          dup;
      bit                          abandoned;

      if (restart) mwc_state = '1;
      bound = (point_count > drs_pkg::MAX_POINTS) ? drs_pkg::MAX_POINTS : point_count;
      // Too few points gives the error response without any draw.
      abandoned = (bound < PICKS);
      cand = '0;
      for (int k = 0; k < PICKS && !abandoned; k++) begin
         tries = 0;
         dup   = 1'b1;
         // Draw again on a repeat of an earlier pick, up to the draw limit.
         while (dup && !abandoned) begin
            if (tries >= drs_pkg::DRAW_LIMIT) begin
               abandoned = 1'b1;
            end else begin
               tries++;
               cand = mwc_draw(bound);
               dup  = 1'b0;
               for (int j = 0; j < k; j++)
                  if (picks[j] == cand[drs_pkg::INDEX_W-1:0]) dup = 1'b1;
            end
         end
         if (!abandoned) picks[k] = cand[drs_pkg::INDEX_W-1:0];
      end

      if (abandoned) begin
         want.index = '0;
         want.last  = 1'b1;
         want.error = 1'b1;
         expected_picks.push_back(want);
      end else begin
         for (int k = 0; k < PICKS; k++) begin
            want.index = picks[k];
            want.last  = (k == PICKS - 1);
            want.error = 1'b0;
            expected_picks.push_back(want);
         end
      end
   endtask

   // Sample every channel at the clock edge on which its handshake completes.
   always @(posedge clock) begin : monitor
      pick_result_type got;
      pick_result_type want;

      if (reset) begin
         mwc_state      = '1;
         mwc_multiplier = drs_pkg::MULT_RESET;
         mismatch_count = 0;
         expected_picks.delete();
      end else begin
         if (csr_tap.valid && csr_tap.ready) mwc_multiplier = csr_tap.multiplier;
         if (req_tap.valid && req_tap.ready) predict_sample(req_tap.point_count, req_tap.restart);
         if (rsp_tap.valid && rsp_tap.ready) begin
            got.index = rsp_tap.index;
            got.last  = rsp_tap.last;
            got.error = rsp_tap.error;
            if (expected_picks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected response: index %0d last %0b error %0b",
                           got.index, got.last, got.error);
            end else begin
               want = expected_picks.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("response mismatch: expected index %0d last %0b error %0b,",
                            want.index, want.last, want.error);
                     $display(" got index %0d last %0b error %0b",
                              got.index, got.last, got.error);
                  end
               end
            end
         end
      end
      awaited_count = expected_picks.size();
   end

endmodule

>>> dv/distinct_random_index_sampler_test.sv
// Top of the distinct random index sampler testbench: clock, reset, request and
// multiplier stimulus, response back-pressure and the final verdict.
// Depends on drs_pkg, drs_ifs.sv, the sampler itself and index_sample_checker.

module distinct_random_index_sampler_test;

   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 58;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 200;
   localparam int RUN_LIMIT     = 32_000_000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   awaited_count;
   bit   quiet_tail;
   bit   hold_wanted;

   drs_req_if req_if ();
   drs_rsp_if rsp_if ();
   drs_csr_if csr_if ();

   distinct_random_index_sampler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   index_sample_checker sample_check (
      .clock          (clock),
      .reset          (reset),
      .req_tap        (req_if),
      .rsp_tap        (rsp_if),
      .csr_tap        (csr_if),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #RUN_LIMIT;
      $display("CHECK FAILED");
      $finish;
   end

   // Response back-pressure: short random bursts, one long hold, none in the tail.
   initial begin : response_sink
      int gap_left;
      bit held;

      gap_left     = 0;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && hold_wanted) begin
            held     = 1'b1;
            gap_left = LONG_HOLD;
         end else if (gap_left == 0 && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 5);
         end
         if (gap_left > 0) begin
            rsp_if.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Offers one request, possibly after a short gap, and waits until it is taken.
   task automatic send_request(input logic [drs_pkg::CNT_W-1:0] point_count,
                               input logic restart);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.point_count <= point_count;
      req_if.restart     <= restart;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stops offering and waits until every predicted response has arrived.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
   endtask

   // Writes the multiplier once the block is idle.
   task automatic write_multiplier(input logic [drs_pkg::MULT_W-1:0] value);
      drain_responses();
      repeat (4) @(posedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.multiplier <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Point counts lean towards small values, where repeated draws are common.
   function automatic logic [drs_pkg::CNT_W-1:0] random_count();
      int sel;

      sel = $urandom_range(0, 99);
      if (sel < 8)
         return drs_pkg::CNT_W'($urandom_range(0, drs_pkg::SAMPLE_COUNT_DEF - 1));
      else if (sel < 50)
         return drs_pkg::CNT_W'($urandom_range(drs_pkg::SAMPLE_COUNT_DEF, 12));
      else if (sel < 75)
         return drs_pkg::CNT_W'($urandom_range(13, 200));
      else if (sel < 90)
         return drs_pkg::CNT_W'($urandom_range(201, drs_pkg::MAX_POINTS));
      else
         return drs_pkg::CNT_W'($urandom_range(drs_pkg::MAX_POINTS + 1, 2047));
   endfunction

   initial begin : stimulus
      logic [drs_pkg::MULT_W-1:0] mult_value;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.point_count = '0;
      req_if.restart     = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.multiplier  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Short counts, saturation above the point range and restart, at the reset multiplier.
      send_request(11'd0, 1'b1);
      send_request(11'd1, 1'b0);
      send_request(11'd4, 1'b1);
      send_request(11'd5, 1'b0);
      send_request(11'd5, 1'b1);
      send_request(11'd6, 1'b0);
      send_request(11'd1023, 1'b0);
      send_request(11'd1024, 1'b1);
      send_request(11'd1025, 1'b0);
      send_request(11'd2047, 1'b0);
      send_request(11'd1536, 1'b1);
      send_request(11'd682, 1'b0);
      send_request(11'd7, 1'b0);

      // Largest multiplier.
      write_multiplier('1);
      send_request(11'd5, 1'b1);
      send_request(11'd1024, 1'b0);
      send_request(11'd3, 1'b0);

      // A zero multiplier makes the generator repeat, so the request runs into the draw limit.
      write_multiplier('0);
      send_request(11'd5, 1'b1);
      send_request(11'd2, 1'b0);

      // Random phases, each under a fresh multiplier. The generator may be stuck at zero
      // after the phase above, so every phase opens with a restart.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mult_value = $urandom();
         write_multiplier(mult_value);
         quiet_tail = (phase == RANDOM_PHASES - 1);
         send_request(random_count(), 1'b1);
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) hold_wanted = 1'b1;
            if (phase == 2 && n == PHASE_ITEMS / 2) drain_responses();
            send_request(random_count(), $urandom_range(0, 6) == 0);
         end
      end

      // Let everything arrive, then allow time for any stray response.
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
